// ===== rtl/usvg_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// usvg_pkg: shared types and constants of the UV sphere vertex strip generator
// Fixed field widths, pipeline depths and quarter-sine polynomial terms.
// ----------------------------------------------------------------------------
package usvg_pkg;

  localparam int unsigned MAX_SEGMENTS_DEF = 256;
  localparam int unsigned SEG_W    = 9;   // segments register and clamped count
  localparam int unsigned IDX_W    = 8;   // grid_row / grid_col
  localparam int unsigned POS_W    = 16;
  localparam int unsigned TEX_W    = 17;
  localparam int unsigned STRIP_W  = 16;
  localparam int unsigned CNT_W    = 3;
  localparam int unsigned PH_W     = 18;  // phase in 1/262144 turn
  localparam int unsigned QUO_W    = 19;  // floor(idx * 2^18 / d)
  localparam int unsigned DIV_CELLS = QUO_W;
  localparam int unsigned SINE_LAT = 7;
  localparam int unsigned SEG_RESET = 32;

  localparam logic [CNT_W-1:0] CNT_NONE = 3'd0;
  localparam logic [CNT_W-1:0] CNT_PAIR = 3'd2;
  localparam logic [CNT_W-1:0] CNT_QUAD = 3'd4;

  // quarter-sine Horner terms, Q30
  localparam logic [30:0] SIN_A1 = 31'd1686629713;
  localparam logic [30:0] SIN_A3 = 31'd693598668;
  localparam logic [30:0] SIN_A5 = 31'd85569306;
  localparam logic [30:0] SIN_A7 = 31'd5026995;
  localparam logic [30:0] SIN_A9 = 31'd172272;

  typedef struct packed {
    logic [QUO_W-1:0] quo;
    logic [7:0]       rem;
    logic [QUO_W-1:0] rnd;   // round-up flag after each step, newest in bit 0
  } div_lane_t;

  typedef struct packed {
    logic               oor;
    logic [CNT_W-1:0]   cnt;
    logic [STRIP_W-1:0] sa;
    logic [STRIP_W-1:0] sb;
    logic [STRIP_W-1:0] sc;
    logic [STRIP_W-1:0] sd;
    logic [TEX_W-1:0]   tu;
    logic [TEX_W-1:0]   tv;
  } side_t;

endpackage
`default_nettype wire

// ===== rtl/uv_sphere_vertex_strip_gen_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// uv_sphere_vertex_strip_gen_top: UV sphere grid point to vertex and strip
// Position, texture coordinates and triangle-strip indices for one point.
// ----------------------------------------------------------------------------
// One grid point (grid_row, grid_col) enters at every clock edge where start
// is high; busy never rises, so items may follow back to back without gaps.
// Each item comes out in the order taken, marked by a one-cycle done strobe.
// The receiver cannot stall: sample the outputs in the cycle done is high.
// The path holds 29 register stages, the first clocked by the accepting edge
// itself: the division chain (19 cells, one quotient bit of column/(N-1) and
// row/(N-1) per cell), one rounding stage, the 7-stage sine pipeline, one
// product stage and the output register.
// Write segments through cfg_we/cfg_wdata only while no item is in flight;
// the value is clamped to [2, MAX_SEGMENTS] when written. Points at or past
// the segment count come out with out_of_range set and every other field 0.
// ----------------------------------------------------------------------------
module uv_sphere_vertex_strip_gen_top
  import usvg_pkg::*;
#(
  parameter int unsigned MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [SEG_W-1:0]   cfg_wdata,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [IDX_W-1:0]   grid_row,
  input  wire logic [IDX_W-1:0]   grid_col,
  output logic                    done,
  output logic signed [POS_W-1:0] pos_x,
  output logic signed [POS_W-1:0] pos_y,
  output logic signed [POS_W-1:0] pos_z,
  output logic [TEX_W-1:0]        tex_u,
  output logic [TEX_W-1:0]        tex_v,
  output logic [CNT_W-1:0]        strip_count,
  output logic [STRIP_W-1:0]      strip_a,
  output logic [STRIP_W-1:0]      strip_b,
  output logic [STRIP_W-1:0]      strip_c,
  output logic [STRIP_W-1:0]      strip_d,
  output logic                    out_of_range
);

  localparam int unsigned RND_IDX  = DIV_CELLS;
  localparam int unsigned SIDE_LEN = DIV_CELLS + 1 + SINE_LAT + 1;
  localparam logic [SEG_W-1:0] SEG_MAX = SEG_W'(MAX_SEGMENTS);

  // segment count, clamped on write
  logic [SEG_W-1:0] seg_n;
  logic [SEG_W-1:0] seg_n_next;
  logic [7:0]       dv;
  logic [6:0]       hv;

  always_comb begin
    if (cfg_wdata < SEG_W'(2)) begin
      seg_n_next = SEG_W'(2);
    end else if (cfg_wdata > SEG_MAX) begin
      seg_n_next = SEG_MAX;
    end else begin
      seg_n_next = cfg_wdata;
    end
    dv = 8'(seg_n - SEG_W'(1));
    hv = dv[7:1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_n <= SEG_W'(SEG_RESET);
    end else if (cfg_we) begin
      seg_n <= seg_n_next;
    end
  end

  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // strip indices and range check, worked out as the item enters
  side_t      side_in;
  logic [16:0] k;
  logic [SEG_W-1:0] row9, col9;

  always_comb begin
    row9 = {1'b0, grid_row};
    col9 = {1'b0, grid_col};
    k    = 17'(row9 * seg_n) + 17'(col9);
    side_in = '0;
    side_in.oor = (row9 >= seg_n) || (col9 >= seg_n);
    side_in.cnt = CNT_NONE;
    if (!side_in.oor && (row9 + SEG_W'(1) < seg_n)) begin
      side_in.cnt = CNT_PAIR;
      side_in.sa  = k[15:0];
      side_in.sb  = 16'(k + 17'(seg_n));
      // row end adds the degenerate pair, except for the final pair
      if ((col9 + SEG_W'(1) == seg_n) && (row9 + SEG_W'(2) != seg_n)) begin
        side_in.cnt = CNT_QUAD;
        side_in.sc  = 16'(k + 17'(seg_n));
        side_in.sd  = 16'(k + 17'd1);
      end
    end
  end

  // division chains: column (u) and row (v) over d = N - 1
  div_lane_t lane_u [DIV_CELLS];
  div_lane_t lane_v [DIV_CELLS];
  div_lane_t init_u, init_v;

  always_comb begin
    init_u = '0;
    init_v = '0;
    init_u.rem = {1'b0, grid_col[7:1]};
    init_v.rem = {1'b0, grid_row[7:1]};
  end

  for (genvar c = 0; c < DIV_CELLS; c++) begin : g_div
    if (c == 0) begin : g_first
      usvg_div_cell u_cell_u (
        .clk(clk), .d(dv), .h(hv), .bit_in(grid_col[0]),
        .lane_in(init_u), .lane_out(lane_u[c])
      );
      usvg_div_cell u_cell_v (
        .clk(clk), .d(dv), .h(hv), .bit_in(grid_row[0]),
        .lane_in(init_v), .lane_out(lane_v[c])
      );
    end else begin : g_rest
      usvg_div_cell u_cell_u (
        .clk(clk), .d(dv), .h(hv), .bit_in(1'b0),
        .lane_in(lane_u[c-1]), .lane_out(lane_u[c])
      );
      usvg_div_cell u_cell_v (
        .clk(clk), .d(dv), .h(hv), .bit_in(1'b0),
        .lane_in(lane_v[c-1]), .lane_out(lane_v[c])
      );
    end
  end

  // rounding stage: phases and texture coordinates
  div_lane_t       qu, qv;
  logic [PH_W-1:0] ph_u, ph_v;
  logic [TEX_W-1:0] tu_next, tv_next;

  assign qu = lane_u[DIV_CELLS-1];
  assign qv = lane_v[DIV_CELLS-1];

  always_ff @(posedge clk) begin
    ph_u <= PH_W'(qu.quo + QUO_W'(qu.rnd[0]));
    ph_v <= PH_W'(qv.quo[QUO_W-1:1] + PH_W'(qv.rnd[1]));
  end

  always_comb begin
    tu_next = qu.quo[QUO_W-1:2] + TEX_W'(qu.rnd[2]);
    tv_next = qv.quo[QUO_W-1:2] + TEX_W'(qv.rnd[2]);
  end

  // four sines: cos u, sin u, cos v, sin v
  logic [15:0] cu, su, cv, sv;
  logic        ncu, nsu, ncv, nsv;

  usvg_sine_pipe u_cos_u (.clk(clk), .phase(PH_W'(ph_u + PH_W'(65536))), .mag(cu), .neg(ncu));
  usvg_sine_pipe u_sin_u (.clk(clk), .phase(ph_u), .mag(su), .neg(nsu));
  usvg_sine_pipe u_cos_v (.clk(clk), .phase(PH_W'(ph_v + PH_W'(65536))), .mag(cv), .neg(ncv));
  usvg_sine_pipe u_sin_v (.clk(clk), .phase(ph_v), .mag(sv), .neg(nsv));

  // products
  logic [31:0] prod_x, prod_z;
  logic [15:0] cv_p;
  logic        neg_x, neg_y, neg_z;

  always_ff @(posedge clk) begin
    prod_x <= 32'(cu) * 32'(sv);
    prod_z <= 32'(su) * 32'(sv);
    cv_p   <= cv;
    neg_x  <= ncu != nsv;
    neg_z  <= nsu != nsv;
    neg_y  <= ncv;
  end

  // side line: valid and strip fields ride along with the datapath
  logic  vld [SIDE_LEN];
  side_t side [SIDE_LEN];
  side_t side_rnd;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < SIDE_LEN; s++) begin
        vld[s] <= 1'b0;
      end
    end else begin
      vld[0] <= accept;
      for (int s = 1; s < SIDE_LEN; s++) begin
        vld[s] <= vld[s-1];
      end
    end
  end

  // insert texture coordinates at the rounding stage
  always_comb begin
    side_rnd    = side[RND_IDX-1];
    side_rnd.tu = tu_next;
    side_rnd.tv = tv_next;
  end

  always_ff @(posedge clk) begin
    side[0] <= side_in;
    for (int s = 1; s < SIDE_LEN; s++) begin
      if (s == RND_IDX) begin
        side[s] <= side_rnd;
      end else begin
        side[s] <= side[s-1];
      end
    end
  end

  // output stage
  logic [16:0] mx, mz;
  logic [15:0] my;
  side_t       so;

  always_comb begin
    so = side[SIDE_LEN-1];
    mx = 17'((33'(prod_x) + 33'd32768) >> 16);
    mz = 17'((33'(prod_z) + 33'd32768) >> 16);
    my = 16'((17'(cv_p) + 17'd1) >> 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[SIDE_LEN-1];
    end
  end

  always_ff @(posedge clk) begin
    out_of_range <= so.oor;
    if (so.oor) begin
      pos_x <= '0; pos_y <= '0; pos_z <= '0;
      tex_u <= '0; tex_v <= '0;
      strip_count <= CNT_NONE;
      strip_a <= '0; strip_b <= '0; strip_c <= '0; strip_d <= '0;
    end else begin
      pos_x <= neg_x ? POS_W'(17'd0 - mx) : POS_W'(mx);
      pos_z <= neg_z ? POS_W'(17'd0 - mz) : POS_W'(mz);
      pos_y <= neg_y ? POS_W'(16'd0 - my) : my;
      tex_u <= so.tu;
      tex_v <= so.tv;
      strip_count <= so.cnt;
      strip_a <= so.sa;
      strip_b <= so.sb;
      strip_c <= so.sc;
      strip_d <= so.sd;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/usvg_div_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// usvg_div_cell: one restoring-division step
// Takes in one dividend bit, produces one quotient bit and its round flag.
// ----------------------------------------------------------------------------
module usvg_div_cell
  import usvg_pkg::*;
(
  input  wire logic      clk,
  input  wire logic [7:0] d,
  input  wire logic [6:0] h,
  input  wire logic      bit_in,
  input  wire div_lane_t lane_in,
  output div_lane_t      lane_out
);

  logic [8:0] t;
  logic       ge;
  logic [7:0] rem_new;
  logic       flag;

  always_comb begin
    t       = {lane_in.rem, bit_in};
    ge      = t >= {1'b0, d};
    rem_new = ge ? 8'(t - {1'b0, d}) : t[7:0];
    flag    = ({1'b0, rem_new} + {2'b00, h}) >= {1'b0, d};
  end

  always_ff @(posedge clk) begin
    lane_out.quo <= {lane_in.quo[QUO_W-2:0], ge};
    lane_out.rem <= rem_new;
    lane_out.rnd <= {lane_in.rnd[QUO_W-2:0], flag};
  end

endmodule
`default_nettype wire

// ===== rtl/usvg_sine_pipe.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// usvg_sine_pipe: pipelined sine of an 18-bit phase
// Quadrant fold, Horner polynomial one multiply per stage, Q15 magnitude out.
// ----------------------------------------------------------------------------
module usvg_sine_pipe
  import usvg_pkg::*;
(
  input  wire logic            clk,
  input  wire logic [PH_W-1:0] phase,
  output logic [15:0]          mag,
  output logic                 neg
);

  logic [1:0]  quad;
  logic [16:0] x;
  logic [1:0]  q0, q1, q2, q3, q4, q5;
  logic [16:0] x0, x1, x2r, x3, x4;
  logic [16:0] sq0, sq1, sq2, sq3;
  logic [30:0] p1, p2, p3, p4;
  logic [31:0] s5;
  logic [17:0] qs;
  logic [15:0] mag_next;

  always_comb begin
    quad = phase[17:16];
    x    = quad[0] ? 17'(18'd65536 - {2'b00, phase[15:0]}) : {1'b0, phase[15:0]};
    qs   = 18'((33'(s5) + 33'd16384) >> 15);
    mag_next = (qs > 18'd32768) ? 16'd32768 : qs[15:0];
  end

  always_ff @(posedge clk) begin
    // fold and square
    q0  <= quad;
    x0  <= x;
    sq0 <= 17'((34'(x) * 34'(x)) >> 16);
    // Horner steps
    q1 <= q0; x1 <= x0; sq1 <= sq0;
    p1 <= 31'(48'(SIN_A7) - ((48'(SIN_A9) * 48'(sq0)) >> 16));
    q2 <= q1; x2r <= x1; sq2 <= sq1;
    p2 <= 31'(48'(SIN_A5) - ((48'(p1) * 48'(sq1)) >> 16));
    q3 <= q2; x3 <= x2r; sq3 <= sq2;
    p3 <= 31'(48'(SIN_A3) - ((48'(p2) * 48'(sq2)) >> 16));
    q4 <= q3; x4 <= x3;
    p4 <= 31'(48'(SIN_A1) - ((48'(p3) * 48'(sq3)) >> 16));
    // scale by x, then round to Q15
    q5 <= q4;
    s5 <= 32'((48'(p4) * 48'(x4)) >> 16);
    mag <= mag_next;
    neg <= q5[1] && (mag_next != 16'd0);
  end

endmodule
`default_nettype wire

// ===== tb/tb_uv_sphere_vertex_strip_gen_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_uv_sphere_vertex_strip_gen_top: self-checking bench for the sphere block
// Drives grid points with random gaps under several segment counts and checks
// every vertex and strip item against a fixed-point predictor or typed values.
// ----------------------------------------------------------------------------
module tb_uv_sphere_vertex_strip_gen_top;
  import usvg_pkg::*;

  localparam int unsigned LIMIT     = 300000;  // cycles before giving up
  localparam int unsigned DRAIN     = 40;      // extra cycles waited once nothing is owed
  localparam int unsigned N_RANDOM  = 92;      // random items per segment setting
  localparam int unsigned N_DIR     = 12;

  // One vertex item as the block presents it.
  typedef struct packed {
    logic                     oor;
    logic signed [POS_W-1:0]  px;
    logic signed [POS_W-1:0]  py;
    logic signed [POS_W-1:0]  pz;
    logic [TEX_W-1:0]         tu;
    logic [TEX_W-1:0]         tv;
    logic [CNT_W-1:0]         cnt;
    logic [STRIP_W-1:0]       sa;
    logic [STRIP_W-1:0]       sb;
    logic [STRIP_W-1:0]       sc;
    logic [STRIP_W-1:0]       sd;
  } vertex_t;

  // One row of the directed table: the grid point and, where it is obvious,
  // the vertex typed in by hand.
  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             typed;
    vertex_t          want;
  } grid_stim_t;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [SEG_W-1:0]   cfg_wdata;
  logic               start;
  logic               busy;
  logic [IDX_W-1:0]   grid_row;
  logic [IDX_W-1:0]   grid_col;
  logic               done;
  logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
  logic [TEX_W-1:0]   tex_u, tex_v;
  logic [CNT_W-1:0]   strip_count;
  logic [STRIP_W-1:0] strip_a, strip_b, strip_c, strip_d;
  logic               out_of_range;

  uv_sphere_vertex_strip_gen_top uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .start(start), .busy(busy), .grid_row(grid_row), .grid_col(grid_col),
    .done(done), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .tex_u(tex_u), .tex_v(tex_v), .strip_count(strip_count),
    .strip_a(strip_a), .strip_b(strip_b), .strip_c(strip_c), .strip_d(strip_d),
    .out_of_range(out_of_range)
  );

  vertex_t        pending_verts [$];   // vertices owed by the block, oldest first
  logic [SEG_W-1:0] seg_reg;           // bench copy of the segments register
  int unsigned    mismatches;
  int unsigned    cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Quarter-turn sine: x in Q16 of a quarter turn, result Q15, Horner in Q30.
  function automatic longint unsigned quarter_sin(longint unsigned x);
    longint unsigned x2, p, s, q;
    x2 = (x * x) >> 16;
    p  = SIN_A9;
    p  = SIN_A7 - ((p * x2) >> 16);
    p  = SIN_A5 - ((p * x2) >> 16);
    p  = SIN_A3 - ((p * x2) >> 16);
    p  = SIN_A1 - ((p * x2) >> 16);
    s  = (p * x) >> 16;
    q  = (s + 16384) >> 15;
    if (q > 32768) q = 32768;
    return q;
  endfunction

  // Sine of an 18-bit phase as magnitude and sign; negative only if nonzero.
  function automatic void phase_sin(input int unsigned phase,
                                    output longint unsigned mag, output logic neg);
    int unsigned ph, quad, r, x;
    ph   = phase & 32'h3FFFF;
    quad = (ph >> 16) & 3;
    r    = ph & 32'hFFFF;
    x    = quad[0] ? 65536 - r : r;
    mag  = quarter_sin(x);
    neg  = (quad >= 2) && (mag != 0);
  endfunction

  function automatic logic [POS_W-1:0] signed_pos(longint unsigned mag, logic neg);
    logic [POS_W-1:0] m;
    m = mag[POS_W-1:0];
    return neg ? -m : m;
  endfunction

  // Work out the vertex and strip indices of one grid point.
  function automatic vertex_t sphere_vertex(logic [SEG_W-1:0] seg,
                                            logic [IDX_W-1:0] row,
                                            logic [IDX_W-1:0] col);
    vertex_t v;
    int unsigned n, i, j, d, h, ph_u, ph_v, k;
    longint unsigned cu, su, cv, sv, mx, mz, my;
    logic ncu, nsu, ncv, nsv;
    v = '0;
    n = seg;
    if (n < 2) n = 2;
    if (n > MAX_SEGMENTS_DEF) n = MAX_SEGMENTS_DEF;
    i = row;
    j = col;
    if (i >= n || j >= n) begin
      v.oor = 1'b1;
      return v;
    end
    d = n - 1;
    h = d >> 1;
    v.tu = TEX_W'((j * 65536 + h) / d);
    v.tv = TEX_W'((i * 65536 + h) / d);
    ph_u = ((j * 262144 + h) / d) & 32'h3FFFF;
    ph_v = ((i * 131072 + h) / d) & 32'h3FFFF;
    phase_sin(ph_u + 65536, cu, ncu);
    phase_sin(ph_u, su, nsu);
    phase_sin(ph_v + 65536, cv, ncv);
    phase_sin(ph_v, sv, nsv);
    mx = (cu * sv + 32768) >> 16;
    mz = (su * sv + 32768) >> 16;
    my = (cv + 1) >> 1;
    v.px = signed_pos(mx, (ncu != nsv) && mx != 0);
    v.py = signed_pos(my, ncv && my != 0);
    v.pz = signed_pos(mz, (nsu != nsv) && mz != 0);
    if (i + 1 < n) begin
      k     = i * n + j;
      v.cnt = CNT_PAIR;
      v.sa  = STRIP_W'(k);
      v.sb  = STRIP_W'(k + n);
      // row end adds the degenerate pair, except on the very last pair
      if (j == n - 1 && (k + n) != (n * n - 1)) begin
        v.cnt = CNT_QUAD;
        v.sc  = STRIP_W'(k + n);
        v.sd  = STRIP_W'(k + 1);
      end
    end
    return v;
  endfunction

  // Present one grid point after a random gap; hold it until busy is low at
  // an edge, then log what the block owes for it. A zero gap keeps start
  // high, so back-to-back items never lower and raise start in one step.
  task automatic send_point(logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                            logic typed, vertex_t want);
    int unsigned gap;
    gap = $urandom_range(0, 16);
    if ($urandom_range(0, 3) == 0) gap = 0;  // stretches with no idling
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    grid_row <= row;
    grid_col <= col;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_verts = {pending_verts, (typed ? want : sphere_vertex(seg_reg, row, col))};
  endtask

  // Drain the pipeline, then write segments while nothing is in flight.
  task automatic write_segments(logic [SEG_W-1:0] val);
    start <= 1'b0;
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we  <= 1'b0;
    seg_reg = val;
  endtask

  task automatic wait_drained();
    while (pending_verts.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // Random points: mostly inside the grid, with the last row and column
  // favored; the rest is full-range noise that lands outside small grids.
  task automatic random_points(int unsigned count);
    int unsigned n, r, c;
    n = (seg_reg < 2) ? 2 : (seg_reg > MAX_SEGMENTS_DEF ? MAX_SEGMENTS_DEF : seg_reg);
    for (int unsigned t = 0; t < count; t++) begin
      r = $urandom_range(0, n - 1);
      c = $urandom_range(0, n - 1);
      case ($urandom_range(0, 9))
        0: begin
          r = $urandom_range(0, 255);
          c = $urandom_range(0, 255);
        end
        1: c = n - 1;
        2: r = n - 1;
        3: begin
          r = n - 2;
          c = n - 1;
        end
        default: ;
      endcase
      send_point(IDX_W'(r), IDX_W'(c), 1'b0, '0);
      // hold off once, halfway through, until every owed vertex is back
      if (t == count / 2) begin
        start <= 1'b0;
        while (pending_verts.size() != 0) @(posedge clk);
      end
    end
  endtask

  // Compare each strobed vertex against the oldest owed one.
  always @(posedge clk) begin
    vertex_t got, want;
    if (!rst && done) begin
      got = '{oor: out_of_range, px: pos_x, py: pos_y, pz: pos_z, tu: tex_u,
              tv: tex_v, cnt: strip_count, sa: strip_a, sb: strip_b,
              sc: strip_c, sd: strip_d};
      if (pending_verts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item: %p", got);
      end else begin
        want = pending_verts.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected %p", want);
            $display("          actual   %p", got);
          end
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb_uv_sphere_vertex_strip_gen_top: done, errors");
      $finish;
    end
  end

  initial begin
    grid_stim_t dir_tab [N_DIR];
    vertex_t    oor_vert;
    logic [SEG_W-1:0] seg_plan [8];
    oor_vert = '0;
    oor_vert.oor = 1'b1;
    // directed points for the reset count of 32, some inside and some outside
    dir_tab[0]  = '{8'd0,   8'd0,   1'b1, '{1'b0, 16'sd0, 16'sd16384, 16'sd0, 17'd0, 17'd0,
                                           CNT_PAIR, 16'd0, 16'd32, 16'd0, 16'd0}};
    dir_tab[1]  = '{8'd0,   8'd31,  1'b1, '{1'b0, 16'sd0, 16'sd16384, 16'sd0, 17'd65536,
                                           17'd0, CNT_QUAD, 16'd31, 16'd63, 16'd63, 16'd32}};
    dir_tab[2]  = '{8'd32,  8'd0,   1'b1, oor_vert};
    dir_tab[3]  = '{8'd0,   8'd32,  1'b1, oor_vert};
    dir_tab[4]  = '{8'd255, 8'd255, 1'b1, oor_vert};
    dir_tab[5]  = '{8'd31,  8'd0,   1'b0, '0};   // last row: no strip
    dir_tab[6]  = '{8'd31,  8'd31,  1'b0, '0};
    dir_tab[7]  = '{8'd30,  8'd31,  1'b0, '0};   // last pair: no degenerate
    dir_tab[8]  = '{8'd16,  8'd8,   1'b0, '0};
    dir_tab[9]  = '{8'd15,  8'd24,  1'b0, '0};
    dir_tab[10] = '{8'd7,   8'd16,  1'b0, '0};
    dir_tab[11] = '{8'd170, 8'd85,  1'b1, oor_vert};
    seg_plan = '{9'd2, 9'd256, 9'd511, 9'd0, 9'd1, 9'd17, 9'd255, 9'd3};

    mismatches = 0;
    cycles     = 0;
    seg_reg    = SEG_W'(SEG_RESET);
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    start     <= 1'b0;
    grid_row  <= '0;
    grid_col  <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int t = 0; t < N_DIR; t++)
      send_point(dir_tab[t].row, dir_tab[t].col, dir_tab[t].typed, dir_tab[t].want);
    random_points(N_RANDOM);

    // walk the segment settings, extremes and clamped values included
    foreach (seg_plan[p]) begin
      write_segments(seg_plan[p]);
      send_point(8'd0, 8'd0, 1'b0, '0);
      send_point(8'd255, 8'd255, 1'b0, '0);
      random_points(N_RANDOM);
    end

    start <= 1'b0;
    wait_drained();
    if (mismatches == 0 && pending_verts.size() == 0) begin
      $display("tb_uv_sphere_vertex_strip_gen_top: done, clean");
    end else begin
      $display("tb_uv_sphere_vertex_strip_gen_top: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/usvg_pkg.sv
rtl/usvg_div_cell.sv
rtl/usvg_sine_pipe.sv
rtl/uv_sphere_vertex_strip_gen_top.sv
tb/tb_uv_sphere_vertex_strip_gen_top.sv
